### src/wave_sample_playback_mixer_macros.svh
// Assertion helpers shared by the RTL of the wave playback mixer.
`ifndef WAVE_SAMPLE_PLAYBACK_MIXER_MACROS_SVH
`define WAVE_SAMPLE_PLAYBACK_MIXER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WSP_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WSP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/wsp_pkg.sv
package wsp_pkg;

    typedef enum logic [1:0] {
        FUNC_LOAD = 2'd0,
        FUNC_PLAY = 2'd1,
        FUNC_STOP = 2'd2,
        FUNC_TICK = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        FMT_SI16 = 2'd0,
        FMT_SI24 = 2'd1,
        FMT_SI32 = 2'd2,
        FMT_F32  = 2'd3
    } fmt_t;

    typedef enum logic [2:0] {
        CFG_WAVE_IS_STEREO = 3'd0,
        CFG_BUS_IS_STEREO  = 3'd1,
        CFG_SAMPLE_FORMAT  = 3'd2,
        CFG_RATE_STEP      = 3'd3,
        CFG_WAVE_FRAMES    = 3'd4,
        CFG_GAIN           = 3'd5
    } cfg_idx_t;

    localparam int POS_W   = 33;
    localparam int FRAME_W = 17;
    localparam int RAW_W   = 18;
    localparam int BUS_W   = 24;

    localparam logic [19:0] RATE_STEP_RESET = 20'd65536;
    localparam logic [15:0] GAIN_RESET      = 16'h8000;
    localparam logic signed [15:0] S16_MAX  = 16'sh7fff;
    localparam logic signed [15:0] S16_MIN  = -16'sh8000;
    localparam logic [7:0] F32_EXP_SAT      = 8'd143;
    localparam logic [7:0] F32_EXP_BIAS_SH  = 8'd150;

    // Per-transaction information that travels down the pipeline.
    typedef struct packed {
        logic                     tick;
        logic                     add_en;
        logic                     playing;
        logic                     ended;
        logic signed [BUS_W-1:0]  mix_l;
        logic signed [BUS_W-1:0]  mix_r;
    } item_t;

    // IEEE single times 32767, truncated toward zero and saturated to 16 bits.
    function automatic logic signed [15:0] f32_to_s16(input logic [31:0] w);
        logic [7:0]  ex;
        logic [7:0]  ex_eff;
        logic [7:0]  sh;
        logic [23:0] mant;
        logic [38:0] prod;
        logic [38:0] mag;
        logic        neg;
        logic signed [15:0] res;
        ex     = w[30:23];
        neg    = w[31];
        mant   = (ex == 8'd0) ? {1'b0, w[22:0]} : {1'b1, w[22:0]};
        ex_eff = (ex == 8'd0) ? 8'd1 : ex;
        sh     = F32_EXP_BIAS_SH - ex_eff;
        // mant * 32767 without a multiplier.
        prod   = {mant, 15'd0} - {15'd0, mant};
        mag    = (sh >= 8'd39) ? 39'd0 : (prod >> sh);
        if (ex == 8'hff) begin
            if (w[22:0] != 23'd0) begin
                res = 16'sd0;
            end else begin
                res = neg ? S16_MIN : S16_MAX;
            end
        end else if (ex >= F32_EXP_SAT) begin
            res = neg ? S16_MIN : S16_MAX;
        end else if (neg) begin
            res = (mag > 39'd32768) ? S16_MIN : $signed(16'(16'd0 - mag[15:0]));
        end else begin
            res = (mag > 39'd32767) ? S16_MAX : $signed(mag[15:0]);
        end
        return res;
    endfunction

    function automatic logic signed [15:0] to_s16(input logic [31:0] w, input fmt_t fmt);
        logic signed [15:0] res;
        case (fmt)
            FMT_SI16: res = $signed(w[15:0]);
            FMT_SI24: res = $signed(w[23:8]);
            FMT_SI32: res = $signed(w[31:16]);
            FMT_F32:  res = f32_to_s16(w);
            default:  res = 16'sd0;
        endcase
        return res;
    endfunction

    function automatic logic signed [BUS_W-1:0] sat24(input logic signed [BUS_W:0] v);
        logic signed [BUS_W-1:0] res;
        if (v[BUS_W] != v[BUS_W-1]) begin
            res = v[BUS_W] ? {1'b1, {(BUS_W-1){1'b0}}} : {1'b0, {(BUS_W-1){1'b1}}};
        end else begin
            res = v[BUS_W-1:0];
        end
        return res;
    endfunction

endpackage

### src/wave_sample_playback_mixer.sv
// Wave sample playback mixer.
// Input stream (s_): s_tuser carries the item kind (load, play, stop, tick);
// s_tdata carries the load address, the load word and the incoming bus pair.
// Output stream (m_): one result per input transaction, in order, with the
// mixed bus pair in m_tdata and the playing/ended flags in m_tuser.
// Configuration registers are written through cfg_wr_en/cfg_addr/cfg_wdata
// and must only change while no transaction is in flight.
// Throughput: one transaction per cycle while m_tready stays high. Playback
// state is updated at accept time and the wave memory's two read ports
// fetch both channels of a frame in the same cycle, so consecutive ticks
// never wait on each other.
// Pipeline: memory read, sample decode, gain multiply, mix and saturate.
// Each stage moves only when the one after it is empty or moving, so a
// stalled receiver lets up to three more transactions in before s_tready
// drops.
// Reset clears the pipeline, the playback position and the active flag and
// restores the register defaults; wave memory content is kept and must be
// loaded before it is played. WAVE_WORDS must be a power of two.
`include "wave_sample_playback_mixer_macros.svh"

module wave_sample_playback_mixer #(
    parameter int WAVE_WORDS = 65536
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [15:0] load_addr, [47:16] load_word, [71:48] mix_in_left, [95:72] mix_in_right
    input  logic [95:0]  s_tdata,
    // [1:0] func
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [23:0] mix_out_left, [47:24] mix_out_right
    output logic [47:0]  m_tdata,
    // [0] playing, [1] ended
    output logic [1:0]   m_tuser,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_addr,
    input  logic [19:0]  cfg_wdata
);

    localparam int AW = $clog2(WAVE_WORDS);
    localparam logic [32:0] WORDS = 33'(WAVE_WORDS);

    // Configuration registers.
    logic                 wave_is_stereo_reg;
    logic                 bus_is_stereo_reg;
    wsp_pkg::fmt_t        sample_format_reg;
    logic [19:0]          rate_step_reg;
    logic [16:0]          wave_frames_reg;
    logic [15:0]          gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_is_stereo_reg <= 1'b0;
            bus_is_stereo_reg  <= 1'b1;
            sample_format_reg  <= wsp_pkg::FMT_SI16;
            rate_step_reg      <= wsp_pkg::RATE_STEP_RESET;
            wave_frames_reg    <= 17'd0;
            gain_reg           <= wsp_pkg::GAIN_RESET;
        end else if (cfg_wr_en) begin
            case (wsp_pkg::cfg_idx_t'(cfg_addr))
                wsp_pkg::CFG_WAVE_IS_STEREO: wave_is_stereo_reg <= cfg_wdata[0];
                wsp_pkg::CFG_BUS_IS_STEREO:  bus_is_stereo_reg  <= cfg_wdata[0];
                wsp_pkg::CFG_SAMPLE_FORMAT:  sample_format_reg  <= wsp_pkg::fmt_t'(cfg_wdata[1:0]);
                wsp_pkg::CFG_RATE_STEP:      rate_step_reg      <= cfg_wdata;
                wsp_pkg::CFG_WAVE_FRAMES:    wave_frames_reg    <= cfg_wdata[16:0];
                wsp_pkg::CFG_GAIN:           gain_reg           <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Input fields.
    wsp_pkg::func_t              s_func;
    logic [15:0]                 s_load_addr;
    logic [31:0]                 s_load_word;
    logic signed [23:0]          s_mix_l;
    logic signed [23:0]          s_mix_r;

    assign s_func      = wsp_pkg::func_t'(s_tuser);
    assign s_load_addr = s_tdata[15:0];
    assign s_load_word = s_tdata[47:16];
    assign s_mix_l     = $signed(s_tdata[71:48]);
    assign s_mix_r     = $signed(s_tdata[95:72]);

    // Pipeline control.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;
    logic acc;

    assign en4      = !v4_reg || m_tready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign acc      = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= acc;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // Playback state, updated when a transaction is accepted.
    logic [wsp_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic                        active_reg, active_next;
    logic [wsp_pkg::FRAME_W-1:0] frame;
    logic                        past_end;
    logic                        run_tick;
    logic                        end_tick;
    logic [wsp_pkg::POS_W:0]     pos_sum;

    assign frame    = pos_reg[wsp_pkg::POS_W-1:16];
    assign past_end = frame >= wave_frames_reg;
    assign run_tick = (s_func == wsp_pkg::FUNC_TICK) && active_reg && !past_end;
    assign end_tick = (s_func == wsp_pkg::FUNC_TICK) && active_reg && past_end;
    assign pos_sum  = {1'b0, pos_reg} + {{(wsp_pkg::POS_W-19){1'b0}}, rate_step_reg};

    always_comb begin
        pos_next    = pos_reg;
        active_next = active_reg;
        case (s_func)
            wsp_pkg::FUNC_PLAY: begin
                pos_next    = '0;
                active_next = 1'b1;
            end
            wsp_pkg::FUNC_STOP: begin
                pos_next    = '0;
                active_next = 1'b0;
            end
            wsp_pkg::FUNC_TICK: begin
                if (end_tick) begin
                    pos_next    = '0;
                    active_next = 1'b0;
                end else if (run_tick) begin
                    pos_next = pos_sum[wsp_pkg::POS_W] ? '1 : pos_sum[wsp_pkg::POS_W-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            active_reg <= 1'b0;
        end else if (acc) begin
            pos_reg    <= pos_next;
            active_reg <= active_next;
        end
    end

    // Wave memory: one write port for loads, two read ports for the channels.
    logic [31:0]               wave_mem [WAVE_WORDS];
    logic [31:0]               rd_l_reg, rd_r_reg;
    logic [wsp_pkg::RAW_W-1:0] raw_l, raw_r;
    logic [AW+wsp_pkg::RAW_W-1:0] ext_l, ext_r;
    logic [AW+15:0]            ext_w;
    logic [AW-1:0]             rd_addr_l, rd_addr_r, wr_addr;
    logic                      mem_we;

    assign raw_l     = wave_is_stereo_reg ? {frame, 1'b0} : {1'b0, frame};
    assign raw_r     = wave_is_stereo_reg ? {frame, 1'b1} : {1'b0, frame};
    assign ext_l     = {{AW{1'b0}}, raw_l};
    assign ext_r     = {{AW{1'b0}}, raw_r};
    assign ext_w     = {{AW{1'b0}}, s_load_addr};
    assign rd_addr_l = ext_l[AW-1:0];
    assign rd_addr_r = ext_r[AW-1:0];
    assign wr_addr   = ext_w[AW-1:0];
    assign mem_we    = acc && (s_func == wsp_pkg::FUNC_LOAD) && ({17'd0, s_load_addr} < WORDS);

    // A load and the tick after it land on different edges, so the read sees the new word.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            wave_mem[wr_addr] <= s_load_word;
        end
        if (en1) begin
            rd_l_reg <= wave_mem[rd_addr_l];
            rd_r_reg <= wave_mem[rd_addr_r];
        end
    end

    // Stage 1: item information beside the memory read data.
    wsp_pkg::item_t it1_reg, it1_next;

    always_comb begin
        it1_next.tick    = (s_func == wsp_pkg::FUNC_TICK);
        it1_next.add_en  = run_tick;
        it1_next.playing = active_next;
        it1_next.ended   = end_tick;
        it1_next.mix_l   = s_mix_l;
        it1_next.mix_r   = s_mix_r;
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            it1_reg <= it1_next;
        end
    end

    // Stage 2: decoded 16-bit samples.
    wsp_pkg::item_t     it2_reg;
    logic signed [15:0] smp_l_reg, smp_r_reg;

    always_ff @(posedge aclk) begin
        if (en2) begin
            it2_reg   <= it1_reg;
            smp_l_reg <= wsp_pkg::to_s16(rd_l_reg, sample_format_reg);
            smp_r_reg <= wsp_pkg::to_s16(rd_r_reg, sample_format_reg);
        end
    end

    // Stage 3: gain products.
    wsp_pkg::item_t     it3_reg;
    logic signed [32:0] prod_l_reg, prod_r_reg;
    logic signed [16:0] gain_s;

    assign gain_s = $signed({1'b0, gain_reg});

    always_ff @(posedge aclk) begin
        if (en3) begin
            it3_reg    <= it2_reg;
            prod_l_reg <= smp_l_reg * gain_s;
            prod_r_reg <= smp_r_reg * gain_s;
        end
    end

    // Stage 4: floor scaling, mono fold, bus add and saturation.
    logic signed [17:0] sc_l, sc_r;
    logic signed [18:0] mono_sum;
    logic signed [17:0] add_l, add_r;
    logic signed [24:0] sum_l, sum_r;
    logic signed [23:0] out_l_next, out_r_next;
    logic signed [23:0] out_l_reg, out_r_reg;
    logic               playing_reg, ended_reg;

    // Dropping the low bits of a two's complement value is a floor shift.
    assign sc_l     = prod_l_reg[32:15];
    assign sc_r     = prod_r_reg[32:15];
    assign mono_sum = 19'(sc_l) + 19'(sc_r);

    always_comb begin
        add_l = 18'sd0;
        add_r = 18'sd0;
        if (it3_reg.add_en) begin
            if (bus_is_stereo_reg) begin
                add_l = sc_l;
                add_r = sc_r;
            end else begin
                add_l = mono_sum[18:1];
            end
        end
        sum_l = 25'(it3_reg.mix_l) + 25'(add_l);
        sum_r = 25'(it3_reg.mix_r) + 25'(add_r);
        out_l_next = 24'sd0;
        out_r_next = 24'sd0;
        if (it3_reg.tick) begin
            out_l_next = wsp_pkg::sat24(sum_l);
            if (bus_is_stereo_reg) begin
                out_r_next = wsp_pkg::sat24(sum_r);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            out_l_reg   <= out_l_next;
            out_r_reg   <= out_r_next;
            playing_reg <= it3_reg.playing;
            ended_reg   <= it3_reg.ended;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {out_r_reg, out_l_reg};
    assign m_tuser  = {ended_reg, playing_reg};

    `WSP_ASSERT_NEXT(a_play_restarts, aclk, aresetn, (acc && s_func == wsp_pkg::FUNC_PLAY), (active_reg && pos_reg == '0), "play did not restart playback at position zero")
    `WSP_ASSERT_NEXT(a_end_stops, aclk, aresetn, (acc && end_tick), (!active_reg && pos_reg == '0), "end of wave did not stop playback")
    `WSP_ASSERT_NEXT(a_stall_holds, aclk, aresetn, (v3_reg && v4_reg && !m_tready), (v3_reg && v4_reg), "pipeline lost a transaction while the output stalled")
    `WSP_ASSERT_SAME(a_ready_when_out_free, aclk, aresetn, (!v4_reg), (s_tready), "input stalled although the output register is free")

endmodule

### dv/wave_sample_playback_mixer_tb.sv
module wave_sample_playback_mixer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WAVE_WORDS = 65536;
    localparam int PHASES = 10;
    localparam int PHASE_ITEMS = 180;
    localparam int CYCLE_LIMIT = 1000000;
    localparam longint unsigned POS_LIMIT = 64'h1_FFFF_FFFF;
    localparam longint BUS_TOP = 8388607;
    localparam longint BUS_BOTTOM = -8388608;
    localparam logic [2:0] CFG_UNUSED_IDX = 3'd7;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct {
        wsp_pkg::func_t    func;
        logic [15:0]       addr;
        logic [31:0]       word;
        logic signed [23:0] mix_l;
        logic signed [23:0] mix_r;
    } bus_item_t;

    typedef struct packed {
        logic signed [23:0] out_l;
        logic signed [23:0] out_r;
        logic               playing;
        logic               ended;
    } mix_result_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [19:0] cfg_wdata = '0;

    wave_sample_playback_mixer #(
        .WAVE_WORDS(WAVE_WORDS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the register file.
    logic          cfg_wave_stereo = 1'b0;
    logic          cfg_bus_stereo = 1'b1;
    wsp_pkg::fmt_t cfg_fmt = wsp_pkg::FMT_SI16;
    logic [19:0]   cfg_rate = wsp_pkg::RATE_STEP_RESET;
    logic [16:0]   cfg_frames = '0;
    logic [15:0]   cfg_gain = wsp_pkg::GAIN_RESET;

    // Playback state as predicted from accepted transactions.
    logic [31:0]     pred_mem [WAVE_WORDS];
    longint unsigned pred_pos = 0;
    logic            pred_active = 1'b0;

    // Stimulus-side tracking of playback so no unwritten word is ever read.
    bit              loaded_words [WAVE_WORDS];
    longint unsigned gen_pos = 0;
    logic            gen_active = 1'b0;

    bus_item_t   pending_items[$];
    mix_result_t expected_mix[$];
    int          outstanding = 0;
    int          error_count = 0;
    int          accepted_count = 0;
    int          tick_count = 0;
    int          end_count = 0;
    int          setting_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        s_took = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic signed [23:0] clamp_bus(input longint v);
        if (v > BUS_TOP) return 24'sh7fffff;
        if (v < BUS_BOTTOM) return 24'sh800000;
        return v[23:0];
    endfunction

    // One channel element of a frame, converted to a signed 16-bit sample.
    function automatic longint wave_sample(input longint unsigned frame, input int unsigned ch);
        logic [31:0]     w;
        logic [7:0]      ex;
        longint unsigned mant;
        longint unsigned mag;
        int              sh;
        int unsigned     chans;
        chans = cfg_wave_stereo ? 2 : 1;
        w = pred_mem[(frame * chans + ch) % WAVE_WORDS];
        case (cfg_fmt)
            wsp_pkg::FMT_SI16: return longint'($signed(w[15:0]));
            wsp_pkg::FMT_SI24: return longint'($signed(w[23:8]));
            wsp_pkg::FMT_SI32: return longint'($signed(w[31:16]));
            default: begin
                ex = w[30:23];
                if (ex == 8'hff) return (w[22:0] != 0) ? 0 : (w[31] ? -32768 : 32767);
                if (ex >= 8'd143) begin
                    mag = 64'hFFFF_FFFF;
                end else begin
                    mant = {ex != 8'd0, w[22:0]};
                    sh = 150 - ((ex == 8'd0) ? 1 : ex);
                    mag = (sh >= 64) ? 0 : ((mant * 32767) >> sh);
                end
                if (w[31]) return (mag > 32768) ? -32768 : -longint'(mag);
                return (mag > 32767) ? 32767 : longint'(mag);
            end
        endcase
    endfunction

    function automatic mix_result_t predict_mix(input bus_item_t it);
        mix_result_t     res;
        longint          add_l;
        longint          add_r;
        longint          sl;
        longint          sr;
        longint          g;
        longint unsigned frame;
        res = '0;
        case (it.func)
            wsp_pkg::FUNC_LOAD: pred_mem[it.addr] = it.word;
            wsp_pkg::FUNC_PLAY: begin
                pred_active = 1'b1;
                pred_pos = 0;
            end
            wsp_pkg::FUNC_STOP: begin
                pred_active = 1'b0;
                pred_pos = 0;
            end
            default: begin
                tick_count++;
                add_l = 0;
                add_r = 0;
                if (pred_active) begin
                    frame = pred_pos >> 16;
                    if (frame >= cfg_frames) begin
                        pred_active = 1'b0;
                        pred_pos = 0;
                        res.ended = 1'b1;
                        end_count++;
                    end else begin
                        sl = wave_sample(frame, 0);
                        sr = cfg_wave_stereo ? wave_sample(frame, 1) : sl;
                        g = cfg_gain;
                        sl = (sl * g) >>> 15;
                        sr = (sr * g) >>> 15;
                        if (cfg_bus_stereo) begin
                            add_l = sl;
                            add_r = sr;
                        end else begin
                            add_l = (sl + sr) >>> 1;
                        end
                        pred_pos = pred_pos + cfg_rate;
                        if (pred_pos > POS_LIMIT) pred_pos = POS_LIMIT;
                    end
                end
                res.out_l = clamp_bus(longint'(it.mix_l) + add_l);
                res.out_r = cfg_bus_stereo ? clamp_bus(longint'(it.mix_r) + add_r) : '0;
            end
        endcase
        res.playing = pred_active;
        return res;
    endfunction

    function automatic logic signed [23:0] rand_bus();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
            1: return 24'(int'($urandom_range(0, 80000)) - 40000);
            default: return 24'($urandom);
        endcase
    endfunction

    // Sample words biased toward the corners of every element encoding.
    function automatic logic [31:0] rand_word();
        logic        sgn;
        logic [31:0] w;
        int unsigned p;
        sgn = 1'($urandom);
        w = $urandom;
        case ($urandom_range(0, 4))
            1: w = {sgn, 8'($urandom_range(112, 142)), 23'($urandom)};
            2: begin
                case ($urandom_range(0, 5))
                    0: w = {sgn, 8'hff, 23'h0};
                    1: w = {sgn, 8'hff, 23'($urandom) | 23'h1};
                    2: w = {sgn, 8'h00, 23'($urandom)};
                    3: w = {sgn, 8'($urandom_range(143, 254)), 23'($urandom)};
                    4: w = {sgn, 8'd142, 23'h7fffff};
                    default: w = {sgn, 31'h0};
                endcase
            end
            3: begin
                p = $urandom_range(0, 2);
                w[p*8 +: 16] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            end
            default: ;
        endcase
        return w;
    endfunction

    task automatic push_item(input wsp_pkg::func_t f, input logic [15:0] a,
                             input logic [31:0] w,
                             input logic signed [23:0] l, input logic signed [23:0] r);
        bus_item_t it;
        it.func = f;
        it.addr = a;
        it.word = w;
        it.mix_l = l;
        it.mix_r = r;
        pending_items.push_back(it);
        outstanding++;
    endtask

    task automatic gen_load(input logic [15:0] a, input logic [31:0] w);
        loaded_words[a] = 1'b1;
        push_item(wsp_pkg::FUNC_LOAD, a, w, rand_bus(), rand_bus());
    endtask

    task automatic gen_play();
        gen_active = 1'b1;
        gen_pos = 0;
        push_item(wsp_pkg::FUNC_PLAY, 16'($urandom), $urandom, rand_bus(), rand_bus());
    endtask

    task automatic gen_stop();
        gen_active = 1'b0;
        gen_pos = 0;
        push_item(wsp_pkg::FUNC_STOP, 16'($urandom), $urandom, rand_bus(), rand_bus());
    endtask

    // A tick that is about to read a frame first gets any missing words loaded.
    task automatic gen_tick(input logic signed [23:0] l, input logic signed [23:0] r);
        longint unsigned frame;
        int unsigned     chans;
        int unsigned     a;
        if (gen_active) begin
            frame = gen_pos >> 16;
            if (frame >= cfg_frames) begin
                gen_active = 1'b0;
                gen_pos = 0;
            end else begin
                chans = cfg_wave_stereo ? 2 : 1;
                for (int ch = 0; ch < chans; ch++) begin
                    a = 32'((frame * chans + ch) % WAVE_WORDS);
                    if (!loaded_words[a]) gen_load(a[15:0], rand_word());
                end
                gen_pos = gen_pos + cfg_rate;
                if (gen_pos > POS_LIMIT) gen_pos = POS_LIMIT;
            end
        end
        push_item(wsp_pkg::FUNC_TICK, 16'($urandom), $urandom, l, r);
    endtask

    // Mostly play/tick runs with the occasional stray load, stop or restart.
    task automatic gen_random(input int n);
        int pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (!gen_active) begin
                if (pick < 60) gen_play();
                else if (pick < 80) gen_tick(rand_bus(), rand_bus());
                else if (pick < 90) gen_load(16'($urandom), rand_word());
                else gen_stop();
            end else begin
                if (pick < 86) gen_tick(rand_bus(), rand_bus());
                else if (pick < 90) gen_stop();
                else if (pick < 94) gen_play();
                else gen_load(16'($urandom), rand_word());
            end
        end
    endtask

    task automatic drain_all();
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr = idx;
        cfg_wdata = val;
        case (idx)
            wsp_pkg::CFG_WAVE_IS_STEREO: cfg_wave_stereo = val[0];
            wsp_pkg::CFG_BUS_IS_STEREO:  cfg_bus_stereo = val[0];
            wsp_pkg::CFG_SAMPLE_FORMAT:  cfg_fmt = wsp_pkg::fmt_t'(val[1:0]);
            wsp_pkg::CFG_RATE_STEP:      cfg_rate = val;
            wsp_pkg::CFG_WAVE_FRAMES:    cfg_frames = val[16:0];
            wsp_pkg::CFG_GAIN:           cfg_gain = val[15:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic apply_setting(input logic ws, input logic bs, input wsp_pkg::fmt_t fmt,
                                 input logic [19:0] rate, input logic [16:0] frames,
                                 input logic [15:0] g);
        write_reg(wsp_pkg::CFG_WAVE_IS_STEREO, 20'(ws));
        write_reg(wsp_pkg::CFG_BUS_IS_STEREO, 20'(bs));
        write_reg(wsp_pkg::CFG_SAMPLE_FORMAT, 20'(fmt));
        write_reg(wsp_pkg::CFG_RATE_STEP, rate);
        write_reg(wsp_pkg::CFG_WAVE_FRAMES, 20'(frames));
        write_reg(wsp_pkg::CFG_GAIN, 20'(g));
        setting_count++;
    endtask

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    always @(negedge aclk) begin : drive_blk
        bus_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_took) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {nxt.mix_r, nxt.mix_l, nxt.word, nxt.addr};
                s_tuser <= nxt.func;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin : check_blk
        bus_item_t   seen;
        mix_result_t want;
        mix_result_t got;
        s_took = s_tvalid && s_tready;
        if (aresetn) begin
            if (s_took) begin
                seen.func = wsp_pkg::func_t'(s_tuser);
                seen.addr = s_tdata[15:0];
                seen.word = s_tdata[47:16];
                seen.mix_l = s_tdata[71:48];
                seen.mix_r = s_tdata[95:72];
                expected_mix.push_back(predict_mix(seen));
                accepted_count++;
            end
            if (m_tvalid && m_tready) begin
                got.out_l = m_tdata[23:0];
                got.out_r = m_tdata[47:24];
                got.playing = m_tuser[0];
                got.ended = m_tuser[1];
                if (expected_mix.size() == 0) begin
                    report_error("result transaction with nothing outstanding");
                end else begin
                    want = expected_mix.pop_front();
                    outstanding--;
                    if (got !== want) begin
                        report_error($sformatf(
                            "left %0d/%0d right %0d/%0d playing %0b/%0b ended %0b/%0b (exp/got)",
                            want.out_l, got.out_l, want.out_r, got.out_r,
                            want.playing, got.playing, want.ended, got.ended));
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin : stimulus_blk
        logic [31:0] f32_cases [8];
        f32_cases = '{32'h3f800000, 32'hbf800000, 32'h7f800000, 32'hff800000,
                      32'h7fc00001, 32'h00000001, 32'h47800000, 32'hc0000000};
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset settings: an idle tick passes the bus, and a zero-length wave ends at once.
        gen_tick(24'sh7fffff, 24'sh800000);
        gen_play();
        gen_tick(24'sh800000, 24'sh7fffff);
        drain_all();

        // A write to an index with no register behind it must change nothing.
        write_reg(CFG_UNUSED_IDX, 20'hFFFFF);
        apply_setting(1'b0, 1'b1, wsp_pkg::FMT_F32, 20'd65536, 17'd8, wsp_pkg::GAIN_RESET);
        for (int k = 0; k < 8; k++) gen_load(16'(k), f32_cases[k]);
        gen_play();
        for (int k = 0; k < 9; k++) begin
            if (k[0]) gen_tick(24'sh7fffff, 24'sh800000);
            else gen_tick(24'sh800000, 24'sh7fffff);
        end
        gen_stop();
        gen_tick(rand_bus(), rand_bus());

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_all();
            case (ph)
                0: apply_setting(1'b0, 1'b1, wsp_pkg::FMT_SI16, 20'd65536, 17'd16, 16'd32768);
                1: apply_setting(1'b1, 1'b1, wsp_pkg::FMT_SI24, 20'd32768, 17'd24, 16'd65535);
                2: apply_setting(1'b1, 1'b0, wsp_pkg::FMT_SI32, 20'd98304, 17'd40, 16'd0);
                3: apply_setting(1'b0, 1'b0, wsp_pkg::FMT_F32, 20'd65536, 17'd12, 16'd32768);
                4: apply_setting(1'b1, 1'b1, wsp_pkg::FMT_F32, 20'hFFFFF, 17'd65536, 16'd40000);
                5: apply_setting(1'b0, 1'b1, wsp_pkg::FMT_SI16, 20'd0, 17'd1, 16'd65535);
                6: apply_setting(1'b1, 1'b0, wsp_pkg::FMT_SI24, 20'd1, 17'd3, 16'd12345);
                default: apply_setting(1'($urandom), 1'($urandom),
                                       wsp_pkg::fmt_t'($urandom_range(0, 3)),
                                       ($urandom_range(0, 2) == 0) ?
                                           20'($urandom) : 20'($urandom_range(16384, 131072)),
                                       ($urandom_range(0, 9) == 0) ?
                                           17'(65536 * $urandom_range(0, 1)) :
                                           17'($urandom_range(1, 48)),
                                       16'($urandom));
            endcase
            case (idle_mode_t'(ph % 4))
                IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                IDLE_SEND: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default:   begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            gen_random(PHASE_ITEMS / 2);
            // Let the pipeline run completely dry in the middle of a playback run.
            if (ph == 5) drain_all();
            gen_random(PHASE_ITEMS - PHASE_ITEMS / 2);
        end

        drain_all();
        repeat (10) @(negedge aclk);
        $display("covered %0d transactions over %0d register settings and four idle patterns",
                 accepted_count, setting_count);
        $display("%0d mixer ticks, %0d wave ends, %0d mismatches",
                 tick_count, end_count, error_count);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
